// ===== hw/rtl/arp_pkg.sv =====
// Shared types and constants of the MIDI arpeggiator.
// Used by the core, arp_ctrl and arp_dp; depends on nothing else.
package arp_pkg;

  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_PRESS   = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  localparam logic [3:0] PAT_UP      = 4'd1;
  localparam logic [3:0] PAT_DOWN    = 4'd2;
  localparam logic [3:0] PAT_UPDOWN  = 4'd3;
  localparam logic [3:0] PAT_DOWNUP  = 4'd4;
  localparam logic [3:0] PAT_RANDOM  = 4'd5;
  localparam logic [3:0] PAT_ORD_UP  = 4'd6;
  localparam logic [3:0] PAT_ORD_DN  = 4'd7;
  localparam logic [3:0] PAT_CHORD   = 4'd8;

  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GATE    = 8'd3;

  localparam logic [3:0]  RST_PATTERN = 4'd1;
  localparam logic [2:0]  RST_RANGE   = 3'd1;
  localparam logic [19:0] RST_STEP    = 20'd12000;
  localparam logic [19:0] RST_GATE    = 20'd6000;

  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam logic [15:0] LFSR_MASK = 16'hB400;

  localparam logic [6:0] VEL_ON     = 7'd100;
  localparam logic [6:0] VEL_OFF    = 7'd64;
  localparam logic [7:0] OCT_STRIDE = 8'd12;

  typedef struct packed {
    logic [1:0] operation;
    logic [6:0] key;
  } in_beat_t;

  typedef struct packed {
    logic       event_kind;
    logic [6:0] note_key;
    logic [6:0] velocity;
    logic       last;
  } out_beat_t;

  typedef enum logic [1:0] {
    KSEL_SOUND = 2'd0,
    KSEL_NOTE  = 2'd1,
    KSEL_HELD  = 2'd2
  } ksel_t;

  typedef struct packed {
    logic  load_in;
    logic  do_press;
    logic  do_release;
    logic  gate_dec;
    logic  clr_sound;
    logic  step_reload;
    logic  step_dec;
    logic  lfsr_step;
    logic  div_start;
    logic  div_sel_b;
    logic  cap_a;
    logic  cap_b;
    logic  push;
    logic  push_on;
    ksel_t ksel;
    logic  note_start;
    logic  chord_clr;
    logic  chord_inc;
    logic  si_inc;
    logic  flush;
  } arp_cmd_t;

  typedef struct packed {
    logic gate_hit;
    logic step_due;
    logic sounding;
    logic held_empty;
    logic pat_chord;
    logic pat_rand;
    logic need_b;
    logic div_done;
    logic note_ok;
    logic chord_last;
    logic out_free;
    logic pend_v;
  } arp_stat_t;

endpackage

// ===== hw/rtl/midi_arpeggiator_core.sv =====
// Top level of the MIDI arpeggiator: controller plus datapath.
// Depends on arp_pkg, arp_ctrl, arp_dp and arp_div.
//
//   port group   dir  beat
//   in_*         in   operation and key (in_beat_t)
//   out_*        out  one MIDI event with last flag (out_beat_t)
//   cfg_*        in   register index and 20-bit write data
//
// A press or release beat updates the held-key set; a tick counts down the gate
// and step counters and ends an expired note. A step runs the 32-bit serial
// divider twice for up, down, up-down, down-up and random and once for the
// other patterns but chord, which skips it and sends one note per held key.
// Reset is synchronous and active low.
// A stalled output holds the sequencer until its buffered event moves on.
module midi_arpeggiator_core
  import arp_pkg::*;
#(
  parameter int unsigned MAX_HELD = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_beat_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_beat_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [19:0]          cfg_data
);

  arp_cmd_t  cmd;
  arp_stat_t stat;

  arp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.operation),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  arp_dp #(
    .MAX_HELD(MAX_HELD)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== hw/rtl/arp_div.sv =====
// Restoring divider, one quotient bit per cycle, for the arpeggiator.
// Standalone; instantiated by arp_dp.
module arp_div #(
  parameter int unsigned NW = 32,
  parameter int unsigned DW = 9
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem
);

  localparam int unsigned CNTW = $clog2(NW + 1);

  logic [NW-1:0]   q_r;
  logic [DW-1:0]   r_r;
  logic [DW-1:0]   d_r;
  logic [CNTW-1:0] cnt_r;
  logic            done_r;
  logic [DW:0]     trial;
  logic            fits;

  assign trial = {r_r, q_r[NW-1]};
  assign fits  = (trial >= {1'b0, d_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNTW'(NW);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= dividend;
      r_r <= '0;
      d_r <= divisor;
    end else if (cnt_r != '0) begin
      q_r <= {q_r[NW-2:0], fits};
      r_r <= fits ? DW'(trial - {1'b0, d_r}) : DW'(trial);
    end
  end

  assign done = done_r;
  assign quo  = q_r;
  assign rem  = r_r;

endmodule

// ===== hw/rtl/arp_dp.sv =====
// Datapath of the arpeggiator: held-key set, counters, configuration,
// note selection and result buffering. Depends on arp_pkg and arp_div.
module arp_dp
  import arp_pkg::*;
#(
  parameter int unsigned MAX_HELD = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  arp_cmd_t             cmd,
  output arp_stat_t            stat,
  input  in_beat_t             in_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [19:0]          cfg_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_beat_t            out_data
);

  localparam int unsigned IW = $clog2(MAX_HELD);
  localparam int unsigned CW = $clog2(MAX_HELD + 1);
  localparam int unsigned TW = CW + 3;
  localparam int unsigned DW = TW + 1;

  logic [3:0]  pattern_r;
  logic [2:0]  range_r;
  logic [19:0] sps_r;
  logic [19:0] gate_r;

  logic [6:0]    held_r [MAX_HELD];
  logic [6:0]    held_nxt [MAX_HELD];
  logic [CW-1:0] count_r;
  logic [31:0]   si_r;
  logic          sounding_r;
  logic [6:0]    sound_key_r;
  logic [19:0]   step_cd_r;
  logic [19:0]   gate_cd_r;
  logic [15:0]   lfsr_r;
  logic [6:0]    key_r;
  logic [IW-1:0] chord_i_r;
  logic [DW-1:0] a_rem_r;
  logic [DW-1:0] b_rem_r;
  logic [2:0]    b_quo_r;

  logic          out_v_r;
  out_beat_t     out_r;
  logic          pend_v_r;
  logic          pend_kind_r;
  logic [6:0]    pend_key_r;

  logic [MAX_HELD-1:0] lt;
  logic [MAX_HELD-1:0] hit;
  logic [MAX_HELD-1:0] ge;
  logic                dup;
  logic                found;

  logic [2:0]    range_v;
  logic [TW-1:0] total;
  logic [DW-1:0] tot_d;
  logic [DW-1:0] cyc_raw;
  logic [DW-1:0] cyc;
  logic [DW-1:0] idx_d;
  logic [DW-1:0] kidx_d;
  logic [IW-1:0] kidx;
  logic [2:0]    oct;
  logic [IW-1:0] rd_idx;
  logic [6:0]    held_rd;
  logic [7:0]    note_v;
  logic [6:0]    push_key;
  logic [15:0]   lfsr_nxt;

  logic          div_start;
  logic [31:0]   div_dividend;
  logic [DW-1:0] div_divisor;
  logic          div_done;
  logic [31:0]   div_quo;
  logic [DW-1:0] div_rem;

  assign cfg_ready = 1'b1;

  always_comb begin
    dup   = 1'b0;
    found = 1'b0;
    for (int i = 0; i < MAX_HELD; i++) begin
      lt[i]  = (CW'(i) < count_r) && (held_r[i] < key_r);
      hit[i] = (CW'(i) < count_r) && (held_r[i] == key_r);
      dup    = dup | hit[i];
      ge[i]  = found | hit[i];
      found  = found | hit[i];
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_HELD; i++) begin
      held_nxt[i] = held_r[i];
      if (cmd.do_press) begin
        if (lt[i]) begin
          held_nxt[i] = held_r[i];
        end else if (i == 0) begin
          held_nxt[i] = key_r;
        end else if (lt[(i == 0) ? 0 : i - 1]) begin
          held_nxt[i] = key_r;
        end else begin
          held_nxt[i] = held_r[(i == 0) ? 0 : i - 1];
        end
      end else if (cmd.do_release) begin
        if (ge[i] && (i + 1 < MAX_HELD)) begin
          held_nxt[i] = held_r[(i + 1 < MAX_HELD) ? i + 1 : i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_press && !dup && (count_r != CW'(MAX_HELD))) begin
      for (int i = 0; i < MAX_HELD; i++) begin
        held_r[i] <= held_nxt[i];
      end
    end else if (cmd.do_release && found) begin
      for (int i = 0; i < MAX_HELD; i++) begin
        held_r[i] <= held_nxt[i];
      end
    end
  end

  assign range_v = (range_r == 3'd0) ? 3'd1 : range_r;
  assign total   = TW'(count_r) * TW'(range_v);
  assign tot_d   = DW'(total);
  assign cyc_raw = {total, 1'b0} - DW'(2);
  assign cyc     = (cyc_raw == '0) ? DW'(1) : cyc_raw;

  always_comb begin
    case (pattern_r)
      PAT_DOWN:   idx_d = tot_d - DW'(1) - a_rem_r;
      PAT_UPDOWN: idx_d = (a_rem_r < tot_d) ? a_rem_r : cyc - a_rem_r;
      PAT_DOWNUP: idx_d = (a_rem_r < tot_d) ? tot_d - DW'(1) - a_rem_r
                                            : a_rem_r - tot_d + DW'(1);
      default:    idx_d = a_rem_r;
    endcase
  end

  always_comb begin
    case (pattern_r)
      PAT_UP, PAT_DOWN, PAT_UPDOWN, PAT_DOWNUP: begin
        kidx_d = b_rem_r;
        oct    = b_quo_r;
      end
      PAT_RANDOM: begin
        kidx_d = a_rem_r;
        oct    = b_rem_r[2:0];
      end
      PAT_ORD_UP: begin
        kidx_d = a_rem_r;
        oct    = 3'd0;
      end
      PAT_ORD_DN: begin
        kidx_d = DW'(count_r) - DW'(1) - a_rem_r;
        oct    = 3'd0;
      end
      default: begin
        kidx_d = '0;
        oct    = 3'd0;
      end
    endcase
  end

  assign kidx    = kidx_d[IW-1:0];
  assign rd_idx  = (pattern_r == PAT_CHORD) ? chord_i_r : kidx;
  assign held_rd = held_r[rd_idx];
  assign note_v  = {1'b0, held_rd} + 8'(oct) * OCT_STRIDE;

  assign div_start = cmd.div_start;
  always_comb begin
    if (cmd.div_sel_b) begin
      if (pattern_r == PAT_RANDOM) begin
        div_dividend = 32'(lfsr_r);
        div_divisor  = DW'(range_v);
      end else begin
        div_dividend = 32'(idx_d[TW-1:0]);
        div_divisor  = DW'(count_r);
      end
    end else begin
      div_dividend = (pattern_r == PAT_RANDOM) ? 32'(lfsr_r) : si_r;
      case (pattern_r)
        PAT_UP, PAT_DOWN:       div_divisor = tot_d;
        PAT_UPDOWN, PAT_DOWNUP: div_divisor = cyc;
        default:                div_divisor = DW'(count_r);
      endcase
    end
  end

  arp_div #(
    .NW(32),
    .DW(DW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      key_r <= in_data.key;
    end
    if (cmd.cap_a) begin
      a_rem_r <= div_rem;
    end
    if (cmd.cap_b) begin
      b_rem_r <= div_rem;
      b_quo_r <= div_quo[2:0];
    end
    if (cmd.chord_clr) begin
      chord_i_r <= '0;
    end else if (cmd.chord_inc) begin
      chord_i_r <= chord_i_r + IW'(1);
    end
  end

  assign lfsr_nxt = (lfsr_r >> 1) ^ (lfsr_r[0] ? LFSR_MASK : 16'h0000);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r   <= RST_PATTERN;
      range_r     <= RST_RANGE;
      sps_r       <= RST_STEP;
      gate_r      <= RST_GATE;
      count_r     <= '0;
      si_r        <= '0;
      sounding_r  <= 1'b0;
      sound_key_r <= '0;
      step_cd_r   <= '0;
      gate_cd_r   <= '0;
      lfsr_r      <= LFSR_SEED;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PATTERN: pattern_r <= cfg_data[3:0];
          CFG_RANGE:   range_r   <= cfg_data[2:0];
          CFG_STEP:    sps_r     <= cfg_data;
          CFG_GATE:    gate_r    <= cfg_data;
          default:     ;
        endcase
      end
      if (cmd.do_press && !dup && (count_r != CW'(MAX_HELD))) begin
        count_r <= count_r + CW'(1);
      end
      if (cmd.do_release) begin
        if (found) begin
          count_r <= count_r - CW'(1);
        end
        if ((count_r == '0) || (found && (count_r == CW'(1)))) begin
          si_r <= '0;
        end
      end
      if (cmd.si_inc) begin
        si_r <= si_r + 32'd1;
      end
      if (cmd.gate_dec && sounding_r && (gate_cd_r != '0)) begin
        gate_cd_r <= gate_cd_r - 20'd1;
      end
      if (cmd.clr_sound) begin
        sounding_r <= 1'b0;
      end
      if (cmd.note_start) begin
        sounding_r  <= 1'b1;
        sound_key_r <= note_v[6:0];
        gate_cd_r   <= gate_r;
      end
      if (cmd.step_reload) begin
        step_cd_r <= sps_r;
      end else if (cmd.step_dec) begin
        step_cd_r <= step_cd_r - 20'd1;
      end
      if (cmd.lfsr_step) begin
        lfsr_r <= lfsr_nxt;
      end
    end
  end

  always_comb begin
    case (cmd.ksel)
      KSEL_SOUND: push_key = sound_key_r;
      KSEL_NOTE:  push_key = note_v[6:0];
      default:    push_key = held_rd;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      if (cmd.push) begin
        if (pend_v_r) begin
          out_r.event_kind <= pend_kind_r;
          out_r.note_key   <= pend_key_r;
          out_r.velocity   <= pend_kind_r ? VEL_ON : VEL_OFF;
          out_r.last       <= 1'b0;
          out_v_r          <= 1'b1;
        end else if (out_ready) begin
          out_v_r <= 1'b0;
        end
        pend_kind_r <= cmd.push_on;
        pend_key_r  <= push_key;
        pend_v_r    <= 1'b1;
      end else if (cmd.flush) begin
        out_r.event_kind <= pend_kind_r;
        out_r.note_key   <= pend_key_r;
        out_r.velocity   <= pend_kind_r ? VEL_ON : VEL_OFF;
        out_r.last       <= 1'b1;
        out_v_r          <= 1'b1;
        pend_v_r         <= 1'b0;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  assign stat.gate_hit   = sounding_r && (gate_cd_r == 20'd1);
  assign stat.step_due   = (step_cd_r <= 20'd1);
  assign stat.sounding   = sounding_r;
  assign stat.held_empty = (count_r == '0);
  assign stat.pat_chord  = (pattern_r == PAT_CHORD);
  assign stat.pat_rand   = (pattern_r == PAT_RANDOM);
  assign stat.need_b     = (pattern_r == PAT_UP) || (pattern_r == PAT_DOWN) ||
                           (pattern_r == PAT_UPDOWN) || (pattern_r == PAT_DOWNUP) ||
                           (pattern_r == PAT_RANDOM);
  assign stat.div_done   = div_done;
  assign stat.note_ok    = !note_v[7];
  assign stat.chord_last = ((CW'(chord_i_r) + CW'(1)) == count_r);
  assign stat.out_free   = !out_v_r || out_ready;
  assign stat.pend_v     = pend_v_r;

endmodule

// ===== hw/rtl/arp_ctrl.sv =====
// Sequencing state machine of the arpeggiator.
// Depends on arp_pkg; drives arp_dp through command and status structs.
module arp_ctrl
  import arp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_op,
  output logic       in_ready,
  output arp_cmd_t   cmd,
  input  arp_stat_t  stat
);

  typedef enum logic [15:0] {
    ST_IDLE    = 16'h0001,
    ST_PRESS   = 16'h0002,
    ST_REL     = 16'h0004,
    ST_GATE    = 16'h0008,
    ST_GOFF    = 16'h0010,
    ST_STEPCHK = 16'h0020,
    ST_SOFF    = 16'h0040,
    ST_CHORD   = 16'h0080,
    ST_ROUTE   = 16'h0100,
    ST_DIVA    = 16'h0200,
    ST_WAITA   = 16'h0400,
    ST_DIVB    = 16'h0800,
    ST_WAITB   = 16'h1000,
    ST_NOTE    = 16'h2000,
    ST_INCS    = 16'h4000,
    ST_FLUSH   = 16'h8000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   can_push;

  assign can_push = !stat.pend_v || stat.out_free;

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          if (in_op == OP_PRESS) begin
            state_nxt = ST_PRESS;
          end else if (in_op == OP_RELEASE) begin
            state_nxt = ST_REL;
          end else if (in_op == OP_TICK) begin
            state_nxt = ST_GATE;
          end
        end
      end
      ST_PRESS: begin
        cmd.do_press = 1'b1;
        state_nxt    = ST_IDLE;
      end
      ST_REL: begin
        cmd.do_release = 1'b1;
        state_nxt      = ST_IDLE;
      end
      ST_GATE: begin
        cmd.gate_dec = 1'b1;
        state_nxt    = stat.gate_hit ? ST_GOFF : ST_STEPCHK;
      end
      ST_GOFF: begin
        cmd.ksel = KSEL_SOUND;
        if (can_push) begin
          cmd.push      = 1'b1;
          cmd.clr_sound = 1'b1;
          state_nxt     = ST_STEPCHK;
        end
      end
      ST_STEPCHK: begin
        if (stat.step_due) begin
          cmd.step_reload = 1'b1;
          state_nxt       = ST_SOFF;
        end else begin
          cmd.step_dec = 1'b1;
          state_nxt    = ST_FLUSH;
        end
      end
      ST_SOFF: begin
        cmd.ksel = KSEL_SOUND;
        if (stat.sounding) begin
          if (can_push) begin
            cmd.push      = 1'b1;
            cmd.clr_sound = 1'b1;
          end
        end else if (stat.held_empty) begin
          state_nxt = ST_FLUSH;
        end else if (stat.pat_chord) begin
          cmd.chord_clr = 1'b1;
          state_nxt     = ST_CHORD;
        end else begin
          state_nxt = ST_ROUTE;
        end
      end
      ST_CHORD: begin
        cmd.ksel    = KSEL_HELD;
        cmd.push_on = 1'b1;
        if (can_push) begin
          cmd.push      = 1'b1;
          cmd.chord_inc = 1'b1;
          if (stat.chord_last) begin
            state_nxt = ST_INCS;
          end
        end
      end
      ST_ROUTE: begin
        cmd.lfsr_step = stat.pat_rand;
        state_nxt     = ST_DIVA;
      end
      ST_DIVA: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_WAITA;
      end
      ST_WAITA: begin
        if (stat.div_done) begin
          cmd.cap_a = 1'b1;
          if (stat.need_b) begin
            cmd.lfsr_step = stat.pat_rand;
            state_nxt     = ST_DIVB;
          end else begin
            state_nxt = ST_NOTE;
          end
        end
      end
      ST_DIVB: begin
        cmd.div_start = 1'b1;
        cmd.div_sel_b = 1'b1;
        state_nxt     = ST_WAITB;
      end
      ST_WAITB: begin
        cmd.div_sel_b = 1'b1;
        if (stat.div_done) begin
          cmd.cap_b = 1'b1;
          state_nxt = ST_NOTE;
        end
      end
      ST_NOTE: begin
        cmd.ksel    = KSEL_NOTE;
        cmd.push_on = 1'b1;
        if (!stat.note_ok) begin
          state_nxt = ST_INCS;
        end else if (can_push) begin
          cmd.push       = 1'b1;
          cmd.note_start = 1'b1;
          state_nxt      = ST_INCS;
        end
      end
      ST_INCS: begin
        cmd.si_inc = 1'b1;
        state_nxt  = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (!stat.pend_v) begin
          state_nxt = ST_IDLE;
        end else if (stat.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
